FILE: rtl/rte_pkg.sv
// Shared types and constants for the rotary encoder / push switch decoder.
// Used by every module under rtl/; depends on nothing.
package rte_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned DebW  = 8;
  localparam int unsigned PressW = 16;
  localparam int unsigned DetW  = 3;
  localparam int unsigned StepW = 4;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;

  localparam logic [CfgAddrW-1:0] REG_ROTATE_DEBOUNCE = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_MIN_PRESS       = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_LONG_PRESS      = 2'd2;
  localparam logic [CfgAddrW-1:0] REG_STEPS_PER_DET   = 2'd3;

  localparam logic [DebW-1:0]   RST_ROTATE_DEBOUNCE = 8'd5;
  localparam logic [PressW-1:0] RST_MIN_PRESS       = 16'd50;
  localparam logic [PressW-1:0] RST_LONG_PRESS      = 16'd1000;
  localparam logic [DetW-1:0]   RST_STEPS_PER_DET   = 3'd2;
  localparam logic [1:0]        RST_QUAD_PHASE      = 2'b11;

  typedef enum logic {
    FUNC_PIN  = 1'b0,
    FUNC_POLL = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    EV_SHORT        = 3'd0,
    EV_RELEASE_LONG = 3'd1,
    EV_CW           = 3'd2,
    EV_CCW          = 3'd3,
    EV_LONG         = 3'd4
  } event_code_t;

  typedef struct packed {
    func_t            func;
    logic [TimeW-1:0] now_ms;
    logic             switch_level;
    logic             clk_level;
    logic             dt_level;
  } item_t;

  typedef struct packed {
    logic        vld;
    event_code_t code;
  } ev_t;

  // Gray-code transition: previous phase {clk,dt} to next phase -> -1, 0, +1
  function automatic logic signed [1:0] quad_dir(input logic [1:0] prev,
                                                 input logic [1:0] next);
    logic signed [1:0] d;
    d = 2'sd0;
    case ({prev, next})
      4'b0001: d = -2'sd1;
      4'b0010: d = 2'sd1;
      4'b0100: d = 2'sd1;
      4'b0111: d = -2'sd1;
      4'b1000: d = -2'sd1;
      4'b1011: d = 2'sd1;
      4'b1101: d = 2'sd1;
      4'b1110: d = -2'sd1;
      default: d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/rotary_encoder_with_push_switch.sv
// Top level of the rotary encoder / push switch event decoder.
// Depends on rte_pkg, rte_in_stage, rte_decode and rte_out_stage.
//
// Each input word (pin change or time poll) enters the input register and a
// new one can follow every cycle: while a word sits in the input register,
// the decoder updates its state and loads at most one event into the result
// register, so throughput is one word per cycle while out_tready is high.
// Words that cause no event leave nothing on the output. Configuration
// writes take effect on the next cycle and are meant for an idle block.
module rotary_encoder_with_push_switch import rte_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  // [31:0] now_ms, [32] switch_level, [33] clk_level, [34] dt_level, rest zero
  input  logic [InDataW-1:0]  in_tdata,
  // [0] func
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // [2:0] event_code, rest zero
  output logic [OutDataW-1:0] out_tdata
);

  logic  item_vld;
  item_t item;
  logic  adv;
  logic  fire;
  ev_t   ev;

  assign fire = item_vld && adv;

  rte_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .pop       (adv),
    .item_vld  (item_vld),
    .item      (item)
  );

  rte_decode u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item),
    .ev        (ev)
  );

  rte_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .ev         (ev),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: rtl/rte_in_stage.sv
// Input register stage: captures one slave-side word and unpacks its fields.
// Depends on rte_pkg.
module rte_in_stage import rte_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [InDataW-1:0] in_tdata,
  input  logic               in_tuser,
  input  logic               pop,
  output logic               item_vld,
  output item_t              item
);

  logic  vld_r;
  item_t item_r;

  assign in_tready = !vld_r || pop;
  assign item_vld  = vld_r;
  assign item      = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.func         <= func_t'(in_tuser);
      item_r.now_ms       <= in_tdata[TimeW-1:0];
      item_r.switch_level <= in_tdata[TimeW];
      item_r.clk_level    <= in_tdata[TimeW+1];
      item_r.dt_level     <= in_tdata[TimeW+2];
    end
  end

endmodule

FILE: rtl/rte_decode.sv
// Decoder core: configuration registers, encoder/switch state and the
// per-word event logic. Depends on rte_pkg.
module rte_decode import rte_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                fire,
  input  item_t               item,
  output ev_t                 ev
);

  logic [DebW-1:0]   rot_deb_r;
  logic [PressW-1:0] min_press_r;
  logic [PressW-1:0] long_press_r;
  logic [DetW-1:0]   det_r;

  logic [TimeW-1:0]        last_step_r, last_step_nxt;
  logic [TimeW-1:0]        press_start_r, press_start_nxt;
  logic                    held_r, held_nxt;
  logic                    long_rep_r, long_rep_nxt;
  logic [1:0]              phase_r, phase_nxt;
  logic signed [StepW-1:0] steps_r, steps_nxt;

  logic [TimeW-1:0]        since_step;
  logic [TimeW-1:0]        dur;
  logic                    in_deb;
  logic                    at_rest;
  logic                    long_hit;
  logic                    short_hit;
  logic [1:0]              next_phase;
  logic signed [1:0]       dir;
  logic signed [StepW:0]   sum;
  logic signed [StepW:0]   lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_deb_r    <= RST_ROTATE_DEBOUNCE;
      min_press_r  <= RST_MIN_PRESS;
      long_press_r <= RST_LONG_PRESS;
      det_r        <= RST_STEPS_PER_DET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ROTATE_DEBOUNCE: rot_deb_r    <= cfg_wdata[DebW-1:0];
        REG_MIN_PRESS:       min_press_r  <= cfg_wdata[PressW-1:0];
        REG_LONG_PRESS:      long_press_r <= cfg_wdata[PressW-1:0];
        REG_STEPS_PER_DET:   det_r        <= cfg_wdata[DetW-1:0];
        default: ;
      endcase
    end
  end

  assign since_step = item.now_ms - last_step_r;
  assign dur        = item.now_ms - press_start_r;
  assign in_deb     = since_step < {{(TimeW-DebW){1'b0}}, rot_deb_r};
  assign at_rest    = item.clk_level && item.dt_level;
  assign long_hit   = dur >= {{(TimeW-PressW){1'b0}}, long_press_r};
  assign short_hit  = dur > {{(TimeW-PressW){1'b0}}, min_press_r};
  assign next_phase = {item.clk_level, item.dt_level};
  assign dir        = quad_dir(phase_r, next_phase);
  assign sum        = {steps_r[StepW-1], steps_r} + {{(StepW-1){dir[1]}}, dir};
  assign lim        = $signed({{(StepW+1-DetW){1'b0}}, det_r});

  always_comb begin
    last_step_nxt   = last_step_r;
    press_start_nxt = press_start_r;
    held_nxt        = held_r;
    long_rep_nxt    = long_rep_r;
    phase_nxt       = phase_r;
    steps_nxt       = steps_r;
    ev.vld          = 1'b0;
    ev.code         = EV_SHORT;
    if (item.func == FUNC_POLL) begin
      if (held_r && !long_rep_r && long_hit) begin
        long_rep_nxt = 1'b1;
        ev.vld       = 1'b1;
        ev.code      = EV_LONG;
      end
    end else if (!in_deb) begin
      if (!item.switch_level && at_rest) begin
        if (!held_r) begin
          press_start_nxt = item.now_ms;
          held_nxt        = 1'b1;
          long_rep_nxt    = 1'b0;
          steps_nxt       = '0;
        end
      end else if (item.switch_level && held_r && at_rest) begin
        held_nxt = 1'b0;
        if (long_hit) begin
          ev.vld  = 1'b1;
          ev.code = EV_RELEASE_LONG;
        end else if (short_hit) begin
          ev.vld  = 1'b1;
          ev.code = EV_SHORT;
        end
      end else begin
        phase_nxt = next_phase;
        if (dir != 2'sd0) begin
          last_step_nxt = item.now_ms;
          steps_nxt     = sum[StepW-1:0];
          if (sum >= lim) begin
            steps_nxt = '0;
            ev.vld    = 1'b1;
            ev.code   = EV_CW;
          end else if (sum <= -lim) begin
            steps_nxt = '0;
            ev.vld    = 1'b1;
            ev.code   = EV_CCW;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_step_r   <= '0;
      press_start_r <= '0;
      held_r        <= 1'b0;
      long_rep_r    <= 1'b0;
      phase_r       <= RST_QUAD_PHASE;
      steps_r       <= '0;
    end else if (fire) begin
      last_step_r   <= last_step_nxt;
      press_start_r <= press_start_nxt;
      held_r        <= held_nxt;
      long_rep_r    <= long_rep_nxt;
      phase_r       <= phase_nxt;
      steps_r       <= steps_nxt;
    end
  end

endmodule

FILE: rtl/rte_out_stage.sv
// Result register: holds one event word for the master side.
// Depends on rte_pkg.
module rte_out_stage import rte_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  ev_t                 ev,
  output logic                adv,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata
);

  logic        vld_r;
  event_code_t code_r;

  assign adv        = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_tdata  = {{(OutDataW-3){1'b0}}, code_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= load && ev.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && load && ev.vld) begin
      code_r <= ev.code;
    end
  end

endmodule

FILE: bench/testbench.sv
// Self-checking bench for rotary_encoder_with_push_switch: drives pin-change and poll words,
// predicts press/rotation events in-bench and compares every output word in order.
// Depends on rte_pkg and the RTL top level; needs no files or arguments.
module testbench;
  import rte_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PhaseWords = 58;

  logic clk;
  logic rst_n;
  logic cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [InDataW-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;

  rotary_encoder_with_push_switch u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // register shadows
  logic [DebW-1:0]   deb_ms = RST_ROTATE_DEBOUNCE;
  logic [PressW-1:0] min_ms = RST_MIN_PRESS;
  logic [PressW-1:0] long_ms = RST_LONG_PRESS;
  logic [DetW-1:0]   detent = RST_STEPS_PER_DET;

  // decoder state
  logic [TimeW-1:0] last_step_ms = '0;
  logic [TimeW-1:0] press_start_ms = '0;
  bit held = 1'b0;
  bit long_done = 1'b0;
  logic [1:0] phase = RST_QUAD_PHASE;
  int steps = 0;

  const int gray_step[4][4] = '{'{0, -1, 1, 0}, '{1, 0, 0, -1},
                                '{-1, 0, 0, 1}, '{0, 1, -1, 0}};

  item_t stim_words[$];
  event_code_t pending_events[$];
  item_t cur_word;
  int in_gap = 0;
  int out_hold = 0;
  bit in_idle_en = 1'b1;
  bit out_idle_en = 1'b1;
  int err_cnt = 0;
  int words_sent = 0;
  int events_seen = 0;
  int cycles = 0;
  int settings = 1;

  // generator view of the encoder pins and time
  logic [TimeW-1:0] t_ms = '0;
  logic [1:0] pins = 2'b11;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic decode_word(input item_t w);
    logic [1:0] nxt;
    logic [TimeW-1:0] dur;
    int dir;
    int lim;
    if (w.func == FUNC_POLL) begin
      if (held && !long_done && (w.now_ms - press_start_ms) >= long_ms) begin
        long_done = 1'b1;
        pending_events.push_back(EV_LONG);
      end
    end else if ((w.now_ms - last_step_ms) < deb_ms) begin
      // inside debounce window
    end else if (!w.switch_level && w.clk_level && w.dt_level) begin
      if (!held) begin
        press_start_ms = w.now_ms;
        held = 1'b1;
        long_done = 1'b0;
        steps = 0;
      end
    end else if (w.switch_level && held && w.clk_level && w.dt_level) begin
      dur = w.now_ms - press_start_ms;
      held = 1'b0;
      if (dur >= long_ms) pending_events.push_back(EV_RELEASE_LONG);
      else if (dur > min_ms) pending_events.push_back(EV_SHORT);
    end else begin
      nxt = {w.clk_level, w.dt_level};
      dir = gray_step[phase][nxt];
      lim = int'(detent);
      phase = nxt;
      if (dir != 0) begin
        steps += dir;
        last_step_ms = w.now_ms;
        if (steps >= lim) begin
          steps = 0;
          pending_events.push_back(EV_CW);
        end else if (steps <= -lim) begin
          steps = 0;
          pending_events.push_back(EV_CCW);
        end
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_word(cur_word);
        words_sent++;
        in_gap = in_idle_en ? $urandom_range(0, 11) : 0;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (stim_words.size() > 0) begin
          cur_word = stim_words.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {5'd0, cur_word.dt_level, cur_word.clk_level,
                       cur_word.switch_level, cur_word.now_ms};
          in_tuser <= cur_word.func;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    event_code_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        events_seen++;
        if (pending_events.size() == 0) begin
          $error("event_code: expected none, got %0d", out_tdata[2:0]);
          err_cnt++;
        end else begin
          want = pending_events.pop_front();
          if (out_tdata[2:0] !== want) begin
            $error("event_code: expected %0d, got %0d", want, out_tdata[2:0]);
            err_cnt++;
          end
          if (out_tdata[OutDataW-1:3] !== '0) begin
            $error("pad: expected 0, got %0h", out_tdata[OutDataW-1:3]);
            err_cnt++;
          end
        end
        out_hold = out_idle_en ? $urandom_range(0, 11) : 0;
      end
      if (out_hold > 0) begin
        out_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_pin(input logic [TimeW-1:0] now, input logic sw, input logic [1:0] pv);
    item_t w;
    w.func = FUNC_PIN;
    w.now_ms = now;
    w.switch_level = sw;
    w.clk_level = pv[1];
    w.dt_level = pv[0];
    stim_words.push_back(w);
  endtask

  // pin fields of a poll carry random junk
  task automatic push_poll(input logic [TimeW-1:0] now);
    item_t w;
    w.func = FUNC_POLL;
    w.now_ms = now;
    {w.switch_level, w.clk_level, w.dt_level} = 3'($urandom_range(0, 7));
    stim_words.push_back(w);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_ROTATE_DEBOUNCE: deb_ms = val[DebW-1:0];
      REG_MIN_PRESS:       min_ms = val;
      REG_LONG_PRESS:      long_ms = val;
      REG_STEPS_PER_DET:   detent = val[DetW-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold off until every word is taken and every event is back
  task automatic drain();
    do @(negedge clk);
    while (stim_words.size() != 0 || in_tvalid || pending_events.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [1:0] turn(input logic [1:0] p, input bit cw);
    case (p)
      2'b11:   return cw ? 2'b01 : 2'b10;
      2'b01:   return cw ? 2'b00 : 2'b11;
      2'b00:   return cw ? 2'b10 : 2'b01;
      default: return cw ? 2'b11 : 2'b00;
    endcase
  endfunction

  task automatic gen_phase(input int n);
    int kind;
    int len;
    int k;
    bit cw;
    logic [TimeW-1:0] p0;
    logic [TimeW-1:0] dur;
    item_t w;
    while (stim_words.size() < n) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        // quadrature run, mostly outside the debounce window
        cw = $urandom_range(0, 1);
        len = $urandom_range(1, 16);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 5) == 0) t_ms += $urandom_range(0, deb_ms + 1);
          else t_ms += deb_ms + $urandom_range(0, 3);
          if ($urandom_range(0, 9) == 0) cw = !cw;
          pins = turn(pins, cw);
          push_pin(t_ms, $urandom_range(0, 7) != 0, pins);
        end
      end else if (kind <= 6) begin
        // press, polls, release with durations around the thresholds
        t_ms += deb_ms + $urandom_range(1, 20);
        p0 = t_ms;
        pins = 2'b11;
        push_pin(p0, 1'b0, pins);
        case ($urandom_range(0, 6))
          0: dur = min_ms;
          1: dur = min_ms + 1;
          2: dur = long_ms - 1;
          3: dur = long_ms;
          4: dur = long_ms + 1;
          5: dur = $urandom_range(0, 2 * long_ms + 100);
          default: dur = $urandom_range(0, min_ms + 10);
        endcase
        len = $urandom_range(0, 3);
        for (k = 0; k < len; k++) push_poll(p0 + $urandom_range(0, dur));
        if ($urandom_range(0, 1)) push_poll(p0 + long_ms);
        if ($urandom_range(0, 7) == 0) push_pin(p0 + $urandom_range(0, dur), 1'b0, pins);
        t_ms = p0 + dur;
        push_pin(t_ms, 1'b1, pins);
        if ($urandom_range(0, 3) == 0) push_poll(t_ms + long_ms);
      end else if (kind == 7) begin
        len = $urandom_range(1, 3);
        for (k = 0; k < len; k++) begin
          w = item_t'(36'($urandom_range(0, 7)) << 32 | 36'($urandom));
          w.func = func_t'($urandom_range(0, 1));
          if ($urandom_range(0, 1)) w.now_ms = t_ms + $urandom_range(0, 3);
          stim_words.push_back(w);
        end
      end else if (kind == 8) begin
        push_poll(t_ms + $urandom_range(0, 2000));
      end else begin
        if ($urandom_range(0, 3) == 0) t_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        else t_ms += $urandom_range(0, 5000);
      end
    end
  endtask

  initial begin
    int p;
    wait (rst_n === 1'b1);
    @(negedge clk);

    // rotation both ways, debounce, bad transitions
    push_pin(32'd2, 1'b1, 2'b01);
    push_pin(32'd10, 1'b1, 2'b01);
    push_pin(32'd12, 1'b1, 2'b00);
    push_pin(32'd20, 1'b1, 2'b00);
    push_pin(32'd30, 1'b1, 2'b10);
    push_pin(32'd40, 1'b1, 2'b11);
    push_pin(32'd50, 1'b1, 2'b10);
    push_pin(32'd60, 1'b1, 2'b00);
    push_pin(32'd70, 1'b1, 2'b01);
    push_pin(32'd80, 1'b1, 2'b11);
    push_pin(32'd90, 1'b1, 2'b00);
    push_pin(32'd100, 1'b1, 2'b11);
    // long press, repeated press, polls
    push_pin(32'd200, 1'b0, 2'b11);
    push_pin(32'd210, 1'b0, 2'b11);
    push_poll(32'd300);
    push_poll(32'd1200);
    push_poll(32'd1300);
    push_pin(32'd1400, 1'b1, 2'b11);
    // short press, too-short press, release while not held
    push_pin(32'd2000, 1'b0, 2'b11);
    push_pin(32'd2051, 1'b1, 2'b11);
    push_pin(32'd3000, 1'b0, 2'b11);
    push_pin(32'd3050, 1'b1, 2'b11);
    push_pin(32'd3100, 1'b1, 2'b11);
    // turning with switch low ends in a press that leaves the phase alone
    push_pin(32'd3200, 1'b0, 2'b01);
    push_pin(32'd3300, 1'b0, 2'b00);
    push_pin(32'd3400, 1'b0, 2'b10);
    push_pin(32'd3500, 1'b0, 2'b11);
    push_pin(32'd3600, 1'b1, 2'b11);
    push_pin(32'd3700, 1'b1, 2'b11);
    // press across the time wrap
    push_pin(32'hFFFF_FFF0, 1'b0, 2'b11);
    push_poll(32'hFFFF_FFFF);
    push_pin(32'h0000_0040, 1'b1, 2'b11);
    t_ms = 32'd5000;
    drain();

    for (p = 0; p < 10; p++) begin
      write_reg(REG_ROTATE_DEBOUNCE, p == 1 ? 16'd0 : p == 2 ? 16'd255 : 16'($urandom_range(0, 40)));
      write_reg(REG_MIN_PRESS, p == 3 ? 16'd0 : p == 4 ? 16'hFFFF : 16'($urandom_range(0, 300)));
      write_reg(REG_LONG_PRESS, p == 5 ? 16'd0 : p == 6 ? 16'hFFFF : 16'($urandom_range(0, 2000)));
      write_reg(REG_STEPS_PER_DET, 16'(p % 8));
      settings++;
      in_idle_en = $urandom_range(0, 2) != 0;
      out_idle_en = $urandom_range(0, 2) != 0;
      @(negedge clk);
      gen_phase(PhaseWords);
      drain();
    end

    $display("Run: %0d words sent, %0d events checked, %0d register settings.",
             words_sent, events_seen, settings);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: rotary_encoder_with_push_switch.f
rtl/rte_pkg.sv
rtl/rte_in_stage.sv
rtl/rte_decode.sv
rtl/rte_out_stage.sv
rtl/rotary_encoder_with_push_switch.sv
bench/testbench.sv
